FILE: hw/rtl/gcc_pkg.sv
// shared types, constants and helpers of the graph connectivity checker
package gcc_pkg;

  localparam int unsigned GCC_MAX_VERTICES = 64;  // default row store depth
  localparam int unsigned VERT_W           = 64;  // bits per adjacency row
  localparam int unsigned IDX_W            = 6;   // row index field width
  localparam int unsigned CNT_W            = 7;   // vertex count register width
  localparam logic [CNT_W-1:0] VCOUNT_RST  = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_CHECK
  } gcc_state_e;

  // controller to datapath
  typedef struct packed {
    logic wr;         // store the accepted row
    logic init;       // seed the reached sets, restart the sweep
    logic rd;         // read next row of the sweep
    logic sweep_clr;  // restart the sweep, keep the sets
    logic finish;     // load the result, drop all stored rows
  } gcc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_last;    // current read is the last vertex in use
    logic changed;    // a set grew during the sweep
    logic out_busy;   // result register holds an item that is not taken
  } gcc_sts_t;

  // ones on the vertices in use
  function automatic logic [VERT_W-1:0] vert_mask(input logic [CNT_W-1:0] n);
    logic [VERT_W-1:0] m;
    for (int j = 0; j < VERT_W; j++) begin
      m[j] = (CNT_W'(j) < n);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/gcc_ram.sv
// generic single write port ram with registered read
module gcc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/gcc_ctrl.sv
// controller: row loading, closure sweeps and result hand-off
module gcc_ctrl import gcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_row_i,
  output logic     in_ready_o,
  input  gcc_sts_t sts_i,
  output gcc_cmd_t cmd_o
);

  gcc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr = 1'b1;
          if (last_row_i) begin
            cmd_o.init = 1'b1;
            state_d    = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd_o.rd = 1'b1;
        if (sts_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.changed) begin
          cmd_o.sweep_clr = 1'b1;
          state_d         = ST_SWEEP;
        end else if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // no row read while rows are being loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !cmd_o.rd)
    else $error("row read during load");

  // a sweep always ends with a drain and a check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_CHECK))
    else $error("drain not followed by check");

endmodule

FILE: hw/rtl/gcc_dp.sv
// datapath: row store, reached sets, sweep counter and result register
module gcc_dp import gcc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = GCC_MAX_VERTICES,
  localparam int unsigned AW          = $clog2(MAX_VERTICES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcc_cmd_t          cmd_i,
  output gcc_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [VERT_W-1:0] row_bits_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              weak_o,
  output logic              strong_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0]        vcount_q;
  logic [CNT_W-1:0]        n_act;
  logic [VERT_W-1:0]       mask;
  logic [MAX_VERTICES-1:0] row_vld_q, row_vld_d;
  logic                    wr_in_range;
  logic [AW-1:0]           rd_cnt_q, rd_cnt_d;
  logic                    proc_vld_q;
  logic [AW-1:0]           proc_idx_q;
  logic [VERT_W-1:0]       rdata;
  logic [VERT_W-1:0]       row;
  logic [VERT_W-1:0]       self_bit;
  logic [VERT_W-1:0]       fwd_q, fwd_d, bwd_q, bwd_d, weak_q, weak_d;
  logic                    changed_q, changed_d;
  logic                    out_valid_q;
  logic                    weak_res_q, strong_res_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (vcount_q == '0) begin
      n_act = CNT_W'(1);
    end else if (vcount_q > MaxCnt) begin
      n_act = MaxCnt;
    end else begin
      n_act = vcount_q;
    end
  end

  assign mask = vert_mask(n_act);

  // row store
  assign wr_in_range = ({1'b0, row_index_i} < MaxCnt);

  gcc_ram #(
    .WIDTH(VERT_W),
    .DEPTH(MAX_VERTICES)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr && wr_in_range),
    .waddr_i(row_index_i[AW-1:0]),
    .wdata_i(row_bits_i),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_cnt_q),
    .rdata_o(rdata)
  );

  always_comb begin
    row_vld_d = row_vld_q;
    if (cmd_i.finish) begin
      row_vld_d = '0;
    end else if (cmd_i.wr && wr_in_range) begin
      row_vld_d[row_index_i[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      rd_cnt_q   <= '0;
      proc_vld_q <= 1'b0;
      changed_q  <= 1'b0;
    end else begin
      row_vld_q  <= row_vld_d;
      rd_cnt_q   <= rd_cnt_d;
      proc_vld_q <= cmd_i.rd;
      changed_q  <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      proc_idx_q <= rd_cnt_q;
    end
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (cmd_i.init || cmd_i.sweep_clr) begin
      rd_cnt_d = '0;
    end else if (cmd_i.rd) begin
      rd_cnt_d = rd_cnt_q + AW'(1);
    end
  end

  // per-row closure step, sets updated in place as rows arrive
  assign row      = rdata & mask & {VERT_W{row_vld_q[proc_idx_q]}};
  assign self_bit = VERT_W'(1) << proc_idx_q;

  always_comb begin
    fwd_d     = fwd_q;
    bwd_d     = bwd_q;
    weak_d    = weak_q;
    changed_d = changed_q;
    if (cmd_i.init) begin
      fwd_d     = VERT_W'(1);
      bwd_d     = VERT_W'(1);
      weak_d    = VERT_W'(1);
      changed_d = 1'b0;
    end else if (cmd_i.sweep_clr) begin
      changed_d = 1'b0;
    end else if (proc_vld_q) begin
      if (fwd_q[proc_idx_q]) begin
        fwd_d = fwd_q | row;
      end
      if ((row & bwd_q) != '0) begin
        bwd_d = bwd_q | self_bit;
      end
      if (weak_q[proc_idx_q]) begin
        weak_d = weak_d | row;
      end
      if ((row & weak_q) != '0) begin
        weak_d = weak_d | self_bit;
      end
      if ((fwd_d != fwd_q) || (bwd_d != bwd_q) || (weak_d != weak_q)) begin
        changed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q  <= fwd_d;
    bwd_q  <= bwd_d;
    weak_q <= weak_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      weak_res_q   <= (weak_q == mask);
      strong_res_q <= (fwd_q == mask) && (bwd_q == mask);
    end
  end

  assign out_valid_o = out_valid_q;
  assign weak_o      = weak_res_q;
  assign strong_o    = strong_res_q;

  assign sts_o.rd_last  = ({{(CNT_W-AW){1'b0}}, rd_cnt_q} == (n_act - CNT_W'(1)));
  assign sts_o.changed  = changed_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // vertex zero stays in every set while rows are processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_vld_q |-> (fwd_q[0] && bwd_q[0] && weak_q[0]))
    else $error("vertex zero dropped from a reached set");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  // a sweep restarts at row zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.init || cmd_i.sweep_clr) |=> (rd_cnt_q == '0))
    else $error("sweep did not restart at row zero");

endmodule

FILE: hw/rtl/graph_connectivity_check_core.sv
// top level of the graph connectivity checker
//
//  channel   direction  handshake                   payload
//  input     in         in_valid_i / in_ready_o     row_index_i, row_bits_i, last_row_i
//  result    out        out_valid_o / out_ready_i   weakly_connected_o, strongly_connected_o
//  config    in         cfg_we_i                    cfg_wdata_i (vertex count)
//
// a row without the last mark is stored on its handshake, ready stays high
// a last row starts the closure: sweeps over the n vertices in use, one row
//   read from the row ram per cycle, each sweep followed by a drain and a
//   check, repeated until no reached set grows; at most n sweeps for n vertices
// the single-port row read sets the pace, input is held off during evaluation
// reset empties the row store through per-row valid bits, no clearing pass;
//   the same valid bits are dropped when a result is loaded
// a stalled result waits in its register; the next graph loads meanwhile
module graph_connectivity_check_core import gcc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = GCC_MAX_VERTICES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  // row items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [VERT_W-1:0] row_bits_i,
  input  logic              last_row_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              weakly_connected_o,
  output logic              strongly_connected_o
);

  gcc_cmd_t cmd;
  gcc_sts_t sts;

  // sequencing of load, sweeps and result
  gcc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .last_row_i(last_row_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // row store, closure sets and result register
  gcc_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .row_index_i(row_index_i),
    .row_bits_i (row_bits_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .weak_o     (weakly_connected_o),
    .strong_o   (strongly_connected_o)
  );

endmodule

FILE: verif/graph_connectivity_check_core_tb.sv
// self-checking testbench of the graph connectivity checker core
`timescale 1ns / 100ps

module graph_connectivity_check_core_tb import gcc_pkg::*; ;

  localparam int unsigned STORE_ROWS    = GCC_MAX_VERTICES;
  localparam int unsigned RANDOM_ROWS   = 1050;
  // idle wait once all results are in, before the vertex count is written
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 300;
  // long receiver hold-off, far longer than a small graph takes to load
  localparam int unsigned HOLD_CYCLES   = 3000;
  // watchdog limit, covers the worst closure plus the hold-off
  localparam int unsigned STALL_LIMIT   = 60000;

  // the two flags of one result item
  typedef struct {
    logic weak_ok;
    logic strong_ok;
  } conn_flags_t;

  // one row of the directed stimulus, with the vertex count to set before it
  typedef struct {
    bit              cfg_wr;
    bit [CNT_W-1:0]  cfg_val;
    bit [IDX_W-1:0]  idx;
    bit [VERT_W-1:0] bits;
    bit              last;
    bit              typed;
    bit              weak_ok;
    bit              strong_ok;
  } dir_row_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [VERT_W-1:0] bits;
    logic              last;
  } row_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CNT_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [IDX_W-1:0]  row_index_i;
  logic [VERT_W-1:0] row_bits_i;
  logic              last_row_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              weakly_connected_o;
  logic              strongly_connected_o;

  // predictor state: its own copy of the row store and the vertex count
  logic [VERT_W-1:0] graph_rows [STORE_ROWS] = '{default: '0};
  logic [CNT_W-1:0]  vcount_cfg = VCOUNT_RST;

  // flags awaited from the block, oldest first
  conn_flags_t awaited_flags [$];
  conn_flags_t head_flags;

  int unsigned rows_sent    = 0;
  int unsigned graphs_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned err_cnt      = 0;
  int unsigned holds_done   = 0;
  int unsigned stall_cycles = 0;
  bit          in_gaps_on   = 1'b1;
  bit          out_gaps_on  = 1'b1;
  bit          hold_req     = 1'b0;

  // directed part: reset count, count extremes, reloads, self loops, unloaded rows
  dir_row_t directed_rows [22] = '{
    // empty graph on the 64 vertices left by reset
    '{1'b0, 7'd0,   6'd0,  64'h0,                  1'b1, 1'b1, 1'b0, 1'b0},
    // single vertex, every column beyond it ignored
    '{1'b1, 7'd1,   6'd0,  '1,                     1'b1, 1'b1, 1'b1, 1'b1},
    // count of zero acts as one vertex
    '{1'b1, 7'd0,   6'd63, '1,                     1'b1, 1'b1, 1'b1, 1'b1},
    // count of 127 saturates to the full store: 0 reaches all, only 63 returns
    '{1'b1, 7'd127, 6'd0,  '1,                     1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd63, 64'h1,                  1'b1, 1'b1, 1'b1, 1'b0},
    // row 0 reloaded, the later row wins: two-vertex cycle
    '{1'b1, 7'd2,   6'd0,  64'h0,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd1,  64'h1,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd0,  64'h2,                  1'b1, 1'b1, 1'b1, 1'b1},
    // store was cleared by the result: row 0 never loaded again
    '{1'b0, 7'd0,   6'd1,  64'h1,                  1'b1, 1'b1, 1'b1, 1'b0},
    // self loops only
    '{1'b0, 7'd0,   6'd0,  64'h1,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd1,  64'h2,                  1'b1, 1'b1, 1'b0, 1'b0},
    // edges 2 to 1 and 1 to 0, all reached when direction is ignored
    '{1'b1, 7'd3,   6'd1,  64'h1,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd2,  64'h2,                  1'b1, 1'b1, 1'b1, 1'b0},
    // full fan-out from a middle vertex
    '{1'b1, 7'd64,  6'd5,  '1,                     1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd0,  64'h20,                 1'b1, 1'b1, 1'b1, 1'b0},
    // top vertex and a half-filled row, left to the predictor
    '{1'b0, 7'd0,   6'd0,  64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd63, 64'h1,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd17, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, 1'b0},
    // directed ring of four
    '{1'b1, 7'd4,   6'd0,  64'h2,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd1,  64'h4,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd2,  64'h8,                  1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   6'd3,  64'h1,                  1'b1, 1'b1, 1'b1, 1'b1}
  };

  graph_connectivity_check_core u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .row_index_i          (row_index_i),
    .row_bits_i           (row_bits_i),
    .last_row_i           (last_row_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .weakly_connected_o   (weakly_connected_o),
    .strongly_connected_o (strongly_connected_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [VERT_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly back to back or short, now and then a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  // zero counts as one vertex, anything past the store saturates
  function automatic int unsigned active_vertices(input logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > STORE_ROWS) return STORE_ROWS;
    return v;
  endfunction

  // vertices reached from vertex 0, following edges forward and/or backward
  function automatic logic [VERT_W-1:0] reach_from_root(input int unsigned n,
                                                        input logic [VERT_W-1:0] in_use,
                                                        input bit fwd, input bit bwd);
    logic [VERT_W-1:0] seen, prev, grown, row;
    seen = VERT_W'(1);
    do begin
      prev  = seen;
      grown = seen;
      for (int unsigned i = 0; i < n; i++) begin
        row = graph_rows[i] & in_use;
        if (fwd && prev[i]) grown |= row;
        if (bwd && (row & prev) != '0) grown[i] = 1'b1;
      end
      seen = grown & in_use;
    end while (seen != prev);
    return seen;
  endfunction

  // flags of the graph now held in the predictor's row store
  function automatic conn_flags_t predict_flags();
    int unsigned       n;
    logic [VERT_W-1:0] in_use;
    conn_flags_t       f;
    n         = active_vertices(vcount_cfg);
    in_use    = (n >= VERT_W) ? '1 : (VERT_W'(1) << n) - 1;
    f.weak_ok = (reach_from_root(n, in_use, 1'b1, 1'b1) == in_use);
    f.strong_ok = (reach_from_root(n, in_use, 1'b1, 1'b0) == in_use) &&
                  (reach_from_root(n, in_use, 1'b0, 1'b1) == in_use);
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // offer one row item, wait for the handshake, then update the predictor
  task automatic send_row(input logic [IDX_W-1:0] idx, input logic [VERT_W-1:0] bits,
                          input logic last, input bit typed = 1'b0,
                          input logic weak_ok = 1'b0, input logic strong_ok = 1'b0);
    int unsigned gap;
    conn_flags_t flags;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    row_index_i = idx;
    row_bits_i  = bits;
    last_row_i  = last;
    do @(posedge clk_i); while (!in_ready_o);
    rows_sent++;
    graph_rows[idx] = bits;
    if (last) begin
      // typed rows carry flags that can be read straight off the graph
      if (typed) begin
        flags.weak_ok   = weak_ok;
        flags.strong_ok = strong_ok;
      end else begin
        flags = predict_flags();
      end
      awaited_flags.insert(awaited_flags.size(), flags);
      foreach (graph_rows[i]) graph_rows[i] = '0;
      graphs_sent++;
    end
    @(negedge clk_i);
  endtask

  // vertex count changes only with the block idle
  task automatic set_vcount(input logic [CNT_W-1:0] v);
    in_valid_i = 1'b0;
    while (awaited_flags.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    vcount_cfg = v;
    cfg_writes++;
  endtask

  // one random graph on n vertices, rows in random order
  task automatic send_random_graph(input int unsigned n);
    logic [VERT_W-1:0] plan [STORE_ROWS];
    int unsigned       perm [STORE_ROWS];
    row_item_t         pending_rows [$];
    row_item_t         item;
    logic [VERT_W-1:0] in_use;
    int unsigned       style, j, tmp, a, b, v;
    bit                backward;
    in_use = (n >= VERT_W) ? '1 : (VERT_W'(1) << n) - 1;
    style  = $urandom_range(0, 99);
    foreach (plan[i]) plan[i] = '0;
    for (int unsigned i = 0; i < n; i++) perm[i] = i;
    for (int unsigned i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    if (style < 90) begin
      if (style < 40) begin
        // directed ring through a random vertex order, sometimes cut
        for (int unsigned k = 0; k < n; k++) plan[perm[k]][perm[(k + 1) % n]] = 1'b1;
        if ($urandom_range(0, 3) == 0) plan[perm[$urandom_range(0, n - 1)]] = '0;
      end else if (style < 70) begin
        // spanning tree with random edge directions, now and then a piece left off
        for (int unsigned k = 1; k < n; k++) begin
          a = perm[$urandom_range(0, k - 1)];
          b = perm[k];
          if ($urandom_range(0, 9) == 0) continue;
          if ($urandom_range(0, 1) != 0) plan[a][b] = 1'b1;
          else plan[b][a] = 1'b1;
        end
      end else begin
        // sparse random edges, about two per row
        for (int unsigned i = 0; i < n; i++)
          for (int unsigned k = 0; k < n; k++)
            if ($urandom_range(0, n) < 2) plan[i][k] = 1'b1;
      end
      repeat ($urandom_range(0, 2)) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        plan[a][b] = 1'b1;
      end
      backward = $urandom_range(0, 1);
      for (int unsigned k = 0; k < n; k++) begin
        v = backward ? perm[n - 1 - k] : perm[k];
        // an empty row may be left out entirely
        if (plan[v] == '0 && $urandom_range(0, 1) != 0) continue;
        item.last = 1'b0;
        item.idx  = IDX_W'(v);
        // a throwaway row first, replaced by the real one
        if ($urandom_range(0, 9) == 0) begin
          item.bits = rand_word();
          pending_rows.insert(pending_rows.size(), item);
        end
        // junk in the columns past the vertex count must not matter
        item.bits = plan[v];
        if ($urandom_range(0, 1) != 0) item.bits |= rand_word() & ~in_use;
        pending_rows.insert(pending_rows.size(), item);
        // rows past the vertex count are stored but unused
        if (n < STORE_ROWS && $urandom_range(0, 9) == 0) begin
          item.idx  = IDX_W'($urandom_range(n, STORE_ROWS - 1));
          item.bits = rand_word();
          pending_rows.insert(pending_rows.size(), item);
        end
      end
    end else begin
      // noise: random rows anywhere, sometimes closed early by a stray last mark
      repeat ($urandom_range(1, n + 2)) begin
        item.idx  = IDX_W'($urandom_range(0, STORE_ROWS - 1));
        item.bits = rand_word();
        item.last = ($urandom_range(0, 7) == 0);
        pending_rows.insert(pending_rows.size(), item);
      end
    end
    if (pending_rows.size() == 0) begin
      item.idx  = '0;
      item.bits = rand_word() & ~in_use;
      pending_rows.insert(pending_rows.size(), item);
    end
    while (pending_rows.size() != 0) begin
      item = pending_rows.pop_front();
      send_row(item.idx, item.bits, item.last || pending_rows.size() == 0);
    end
  endtask

  // result side: random ready gaps, plus one long hold-off on request
  initial begin : rx_side
    int unsigned rx_wait;
    rx_wait     = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // sender keeps offering rows meanwhile, so the block fills and stalls
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end
      if (rx_wait != 0) begin
        out_ready_i = 1'b0;
        rx_wait--;
      end else begin
        out_ready_i = 1'b1;
        if (out_gaps_on) rx_wait = pick_gap();
      end
    end
  end

  // compare each result item with the oldest awaited flags
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_flags.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited: weak %b strong %b",
                                  weakly_connected_o, strongly_connected_o));
      end else begin
        head_flags = awaited_flags.pop_front();
        results_seen++;
        if (weakly_connected_o !== head_flags.weak_ok)
          report_mismatch($sformatf("result %0d weakly_connected got %b want %b",
                                    results_seen, weakly_connected_o, head_flags.weak_ok));
        if (strongly_connected_o !== head_flags.strong_ok)
          report_mismatch($sformatf("result %0d strongly_connected got %b want %b",
                                    results_seen, strongly_connected_o, head_flags.strong_ok));
      end
    end
  end

  // watchdog: cycles in a row with no item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results still awaited",
               stall_cycles, awaited_flags.size());
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned      n, graphs, r, random_start;
    bit               hold_asked;
    logic [CNT_W-1:0] vc;
    hold_asked  = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    row_index_i = '0;
    row_bits_i  = '0;
    last_row_i  = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table first
    foreach (directed_rows[k]) begin
      if (directed_rows[k].cfg_wr) set_vcount(directed_rows[k].cfg_val);
      send_row(directed_rows[k].idx, directed_rows[k].bits, directed_rows[k].last,
               directed_rows[k].typed, directed_rows[k].weak_ok, directed_rows[k].strong_ok);
    end

    // random phases: a vertex count, then a handful of graphs at that count
    random_start = rows_sent;
    while (rows_sent - random_start < RANDOM_ROWS) begin
      r = $urandom_range(0, 99);
      if (r < 6)       vc = CNT_W'($urandom_range(0, 1));
      else if (r < 72) vc = CNT_W'($urandom_range(2, 10));
      else if (r < 88) vc = CNT_W'($urandom_range(11, 24));
      else if (r < 94) vc = CNT_W'($urandom_range(25, 63));
      else             vc = CNT_W'($urandom_range(64, 127));
      set_vcount(vc);
      n      = active_vertices(vc);
      // large graphs are slow to close, keep them to one per phase
      graphs = (n >= 25) ? 1 : $urandom_range(3, 8);
      for (int unsigned g = 0; g < graphs; g++) begin
        in_gaps_on  = ($urandom_range(0, 9) < 7);
        out_gaps_on = ($urandom_range(0, 9) < 7);
        // hold-off only with graphs left to send, so rows keep coming
        if (!hold_asked && rows_sent - random_start >= 150 && g + 2 < graphs) begin
          hold_req   = 1'b1;
          hold_asked = 1'b1;
        end
        send_random_graph(n);
      end
    end

    in_valid_i = 1'b0;
    while (awaited_flags.size() != 0) @(negedge clk_i);
    // any stray result after the last one still shows up here
    repeat (END_CYCLES) @(negedge clk_i);

    $display("run covered %0d rows in %0d graphs, %0d results checked, %0d count writes",
             rows_sent, graphs_sent, results_seen, cfg_writes);
    $display("long result hold-offs: %0d, mismatches: %0d", holds_done, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: graph_connectivity_check_core.f
hw/rtl/gcc_pkg.sv
hw/rtl/gcc_ram.sv
hw/rtl/gcc_ctrl.sv
hw/rtl/gcc_dp.sv
hw/rtl/graph_connectivity_check_core.sv
verif/graph_connectivity_check_core_tb.sv
